/* rtl/jdc_pkg.sv */
// Shared constants and helper functions for the calendar date converter.
package jdc_pkg;

	localparam int NSTG = 9;

	localparam int DN_W = 24;
	localparam int EM_W = 48;
	localparam int YR_W = 17;
	localparam int MO_W = 4;
	localparam int DY_W = 5;
	localparam int HR_W = 5;
	localparam int MI_W = 6;
	localparam int SE_W = 6;
	localparam int MS_W = 10;

	localparam logic [23:0] GREG_START = 24'd2299161;
	localparam logic [23:0] EPOCH_JDN  = 24'd2440588;

	// Divisors and their reciprocal scale factors.
	localparam int unsigned D_DAYK = 84375;
	localparam int unsigned S_X1   = 26;
	localparam int unsigned M_X1   = (1 << S_X1) / D_DAYK;
	localparam int unsigned S_X2   = 29;
	localparam int unsigned M_X2   = (1 << S_X2) / D_DAYK;
	localparam int unsigned D_HR   = 3600000;
	localparam int unsigned S_HR   = 27;
	localparam int unsigned M_HR   = (1 << S_HR) / D_HR;
	localparam int unsigned D_MIN  = 60000;
	localparam int unsigned S_MIN  = 22;
	localparam int unsigned M_MIN  = (1 << S_MIN) / D_MIN;
	localparam int unsigned D_SEC  = 1000;
	localparam int unsigned S_SEC  = 16;
	localparam int unsigned M_SEC  = (1 << S_SEC) / D_SEC;
	localparam int unsigned D_GN   = 146097;
	localparam int unsigned S_GN   = 27;
	localparam int unsigned M_GN   = (1 << S_GN) / D_GN;
	localparam int unsigned D_GI   = 1461001;
	localparam int unsigned S_GI   = 28;
	localparam int unsigned M_GI   = (1 << S_GI) / D_GI;
	localparam int unsigned D_GJ   = 2447;
	localparam int unsigned S_GJ   = 16;
	localparam int unsigned M_GJ   = (1 << S_GJ) / D_GJ;
	localparam int unsigned D_JQ   = 1461;
	localparam int unsigned S_JQ   = 27;
	localparam int unsigned M_JQ   = (1 << S_JQ) / D_JQ;
	localparam int unsigned D_JM   = 153;
	localparam int unsigned S_JM   = 11;
	localparam int unsigned M_JM   = (1 << S_JM) / D_JM;

	// Quotient by a constant through a scaled reciprocal and one correction step.
	// The operand must stay below two to the power of the shift.
	function automatic logic [31:0] cdiv(input logic [31:0] x, input int unsigned d,
			input int unsigned m, input int unsigned s);
		logic [63:0] p;
		logic [31:0] qe;
		logic [31:0] r;
		p = {32'd0, x} * 64'(m);
		qe = 32'(p >> s);
		r = x - 32'(qe * d);
		if (r >= d) begin
			qe = qe + 32'd1;
		end
		return qe;
	endfunction

	// Days before the month in the Gregorian rule, indexed by the month code.
	function automatic logic [8:0] greg_moff(input logic [3:0] j);
		logic [8:0] r;
		case (j)
			4'd0: r = 9'd0;
			4'd1: r = 9'd30;
			4'd2: r = 9'd61;
			4'd3: r = 9'd91;
			4'd4: r = 9'd122;
			4'd5: r = 9'd152;
			4'd6: r = 9'd183;
			4'd7: r = 9'd214;
			4'd8: r = 9'd244;
			4'd9: r = 9'd275;
			4'd10: r = 9'd305;
			4'd11: r = 9'd336;
			4'd12: r = 9'd367;
			4'd13: r = 9'd397;
			4'd14: r = 9'd428;
			default: r = 9'd458;
		endcase
		return r;
	endfunction

	// Days before the month in the Julian rule, indexed by the month code.
	function automatic logic [8:0] jul_moff(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/jdc_req_if.sv */
// Request channel: valid, ready and the request fields.
interface jdc_req_if;
	import jdc_pkg::*;
	logic valid;
	logic ready;
	logic req_type;
	logic [DN_W-1:0] day_number;
	logic [EM_W-1:0] epoch_millis;
	modport source(output valid, output req_type, output day_number, output epoch_millis,
		input ready);
	modport sink(input valid, input req_type, input day_number, input epoch_millis,
		output ready);
endinterface

/* rtl/jdc_rsp_if.sv */
// Result channel: valid, ready and the date and time fields.
interface jdc_rsp_if;
	import jdc_pkg::*;
	logic valid;
	logic ready;
	logic signed [YR_W-1:0] year_out;
	logic [MO_W-1:0] month_out;
	logic [DY_W-1:0] day_out;
	logic [HR_W-1:0] hour_out;
	logic [MI_W-1:0] minute_out;
	logic [SE_W-1:0] second_out;
	logic [MS_W-1:0] millis_out;
	modport source(output valid, output year_out, output month_out, output day_out,
		output hour_out, output minute_out, output second_out, output millis_out,
		input ready);
	modport sink(input valid, input year_out, input month_out, input day_out,
		input hour_out, input minute_out, input second_out, input millis_out,
		output ready);
endinterface

/* rtl/jdc_ctl.sv */
// Pipeline valid bits and per-stage advance enables with bubble collapsing.
module jdc_ctl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       out_ready,
	output logic [jdc_pkg::NSTG-1:0]   en,
	output logic                       out_valid
);
	import jdc_pkg::*;

	logic [NSTG-1:0] vld_q;

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign out_valid = vld_q[NSTG-1];

endmodule

/* rtl/jdc_split.sv */
// Millisecond split into day count and time of day, and selection of the day number.
module jdc_split (
	input  logic                          clk,
	input  logic [jdc_pkg::NSTG-1:0]      en,
	input  logic                          req_type,
	input  logic [jdc_pkg::DN_W-1:0]      day_number,
	input  logic [jdc_pkg::EM_W-1:0]      epoch_millis,
	output logic [jdc_pkg::DN_W-1:0]      jd_s3,
	output logic [jdc_pkg::HR_W-1:0]      hh_s5,
	output logic [jdc_pkg::MI_W-1:0]      mi_s5,
	output logic [jdc_pkg::SE_W-1:0]      ss_s5,
	output logic [jdc_pkg::MS_W-1:0]      ms_s5
);
	import jdc_pkg::*;

	logic [31:0] x1, q1w, x2, q2w, x3, q3w, x4, q4w, x5, q5w;

	logic        kind_s1, kind_s2, kind_s3, kind_s4;
	logic [23:0] dn_s1, dn_s2;
	logic [9:0]  q1_s1;
	logic [16:0] r1_s1;
	logic [21:0] lo_s1;
	logic [21:0] day_s2;
	logic [26:0] tod_s2;
	logic [4:0]  hh_s3, hh_s4;
	logic [21:0] rm_s3;
	logic [5:0]  mi_s4;
	logic [15:0] rm_s4;

	// The day divisor 86400000 is 84375 shifted left by ten, so the low ten
	// bits of the count pass straight into the time of day.
	assign x1  = 32'(epoch_millis[47:22]);
	assign q1w = cdiv(x1, D_DAYK, M_X1, S_X1);
	assign x2  = 32'({r1_s1, lo_s1[21:10]});
	assign q2w = cdiv(x2, D_DAYK, M_X2, S_X2);
	assign x3  = 32'(tod_s2);
	assign q3w = cdiv(x3, D_HR, M_HR, S_HR);
	assign x4  = 32'(rm_s3);
	assign q4w = cdiv(x4, D_MIN, M_MIN, S_MIN);
	assign x5  = 32'(rm_s4);
	assign q5w = cdiv(x5, D_SEC, M_SEC, S_SEC);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			kind_s1 <= req_type;
			dn_s1   <= day_number;
			q1_s1   <= q1w[9:0];
			r1_s1   <= 17'(x1 - q1w * D_DAYK);
			lo_s1   <= {epoch_millis[21:10], epoch_millis[9:0]};
		end
		if (en[1]) begin
			kind_s2 <= kind_s1;
			dn_s2   <= dn_s1;
			day_s2  <= {q1_s1, q2w[11:0]};
			tod_s2  <= {17'(x2 - q2w * D_DAYK), lo_s1[9:0]};
		end
		if (en[2]) begin
			kind_s3 <= kind_s2;
			jd_s3   <= kind_s2 ? 24'(day_s2) + EPOCH_JDN : dn_s2;
			hh_s3   <= q3w[4:0];
			rm_s3   <= 22'(x3 - q3w * D_HR);
		end
		if (en[3]) begin
			kind_s4 <= kind_s3;
			hh_s4   <= hh_s3;
			mi_s4   <= q4w[5:0];
			rm_s4   <= 16'(x4 - q4w * D_MIN);
		end
		if (en[4]) begin
			hh_s5 <= kind_s4 ? hh_s4 : '0;
			mi_s5 <= kind_s4 ? mi_s4 : '0;
			ss_s5 <= kind_s4 ? q5w[5:0] : '0;
			ms_s5 <= kind_s4 ? 10'(x5 - q5w * D_SEC) : '0;
		end
	end

endmodule

/* rtl/jdc_date.sv */
// Day number to year, month and day in the Gregorian and Julian rules.
module jdc_date (
	input  logic                              clk,
	input  logic [jdc_pkg::NSTG-1:0]          en,
	input  logic [jdc_pkg::DN_W-1:0]          jd_s3,
	output logic signed [jdc_pkg::YR_W-1:0]   year_s9,
	output logic [jdc_pkg::MO_W-1:0]          month_s9,
	output logic [jdc_pkg::DY_W-1:0]          day_s9
);
	import jdc_pkg::*;

	logic [24:0] l_c, c_c;
	logic [31:0] nw, qw, iw, mw, jw;
	logic [26:0] gn_off, jq_off;
	logic [17:0] l3_c;
	logic [16:0] jy_c;
	logic [3:0]  jmo_c, gmo_c;
	logic        lt_c;
	logic [16:0] gy_c;

	logic        greg_s4, greg_s5, greg_s6, greg_s7, greg_s8;
	logic [24:0] l_s4, c_s4;
	logic [8:0]  n_s4, n_s5, n_s6, n_s7, n_s8;
	logic [15:0] q_s4, q_s5, q_s6;
	logic [15:0] l2_s5, l2_s6;
	logic [8:0]  e_s5, e_s6;
	logic [6:0]  i_s6, i_s7, i_s8;
	logic [3:0]  m_s6;
	logic [8:0]  l3_s7, l3_s8;
	logic [3:0]  j_s8;
	logic [16:0] jy_s7, jy_s8;
	logic [3:0]  jmo_s7, jmo_s8;
	logic [4:0]  jdy_s7, jdy_s8;

	assign l_c = 25'(jd_s3) + 25'd68569;
	assign c_c = 25'(jd_s3) + 25'd32082;
	assign nw  = cdiv(32'({l_c, 2'b00}), D_GN, M_GN, S_GN);
	assign qw  = cdiv(32'({c_c, 2'b00}) + 32'd3, D_JQ, M_JQ, S_JQ);

	assign gn_off = 27'((27'(n_s4) * 27'(D_GN) + 27'd3) >> 2);
	assign jq_off = 27'((27'(q_s4) * 27'(D_JQ)) >> 2);

	assign iw = cdiv((32'(l2_s5) + 32'd1) * 32'd4000, D_GI, M_GI, S_GI);
	assign mw = cdiv(32'(e_s5) * 32'd5 + 32'd2, D_JM, M_JM, S_JM);

	assign l3_c = 18'(l2_s6) + 18'd31 - ((18'(i_s6) * 18'd1461) >> 2);

	always_comb begin
		jy_c = 17'(q_s6) - 17'd4800 + ((m_s6 >= 4'd10) ? 17'd1 : 17'd0);
		// No year zero in the Julian rule: the year before 1 is -1.
		if (jy_c[16] || jy_c == 17'd0) begin
			jy_c = jy_c - 17'd1;
		end
		jmo_c = (m_s6 >= 4'd10) ? m_s6 - 4'd9 : m_s6 + 4'd3;
	end

	assign jw = cdiv(32'(l3_s7) * 32'd80, D_GJ, M_GJ, S_GJ);

	assign lt_c  = (j_s8 >= 4'd11);
	assign gmo_c = lt_c ? j_s8 - 4'd10 : j_s8 + 4'd2;
	assign gy_c  = 17'(n_s8) * 17'd100 - 17'd4900 + 17'(i_s8) + 17'(lt_c);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			greg_s4 <= (jd_s3 >= GREG_START);
			l_s4    <= l_c;
			c_s4    <= c_c;
			n_s4    <= nw[8:0];
			q_s4    <= qw[15:0];
		end
		if (en[4]) begin
			greg_s5 <= greg_s4;
			n_s5    <= n_s4;
			q_s5    <= q_s4;
			l2_s5   <= 16'(l_s4 - 25'(gn_off));
			e_s5    <= 9'(c_s4 - 25'(jq_off));
		end
		if (en[5]) begin
			greg_s6 <= greg_s5;
			n_s6    <= n_s5;
			q_s6    <= q_s5;
			l2_s6   <= l2_s5;
			e_s6    <= e_s5;
			i_s6    <= iw[6:0];
			m_s6    <= mw[3:0];
		end
		if (en[6]) begin
			greg_s7 <= greg_s6;
			n_s7    <= n_s6;
			i_s7    <= i_s6;
			l3_s7   <= l3_c[8:0];
			jy_s7   <= jy_c;
			jmo_s7  <= jmo_c;
			jdy_s7  <= 5'(e_s6 - jul_moff(m_s6) + 9'd1);
		end
		if (en[7]) begin
			greg_s8 <= greg_s7;
			n_s8    <= n_s7;
			i_s8    <= i_s7;
			l3_s8   <= l3_s7;
			j_s8    <= jw[3:0];
			jy_s8   <= jy_s7;
			jmo_s8  <= jmo_s7;
			jdy_s8  <= jdy_s7;
		end
		if (en[8]) begin
			year_s9  <= greg_s8 ? signed'(gy_c) : signed'(jy_s8);
			month_s9 <= greg_s8 ? gmo_c : jmo_s8;
			day_s9   <= greg_s8 ? 5'(l3_s8 - greg_moff(j_s8)) : jdy_s8;
		end
	end

endmodule

/* rtl/julian_day_to_calendar_date.sv */
// Top level of the calendar date converter.
// An accepted request moves through the stage registers s1 to s9; s9 is the output register.
// Throughput: one request per cycle; a stalled output holds the pipeline stage by stage,
// and empty stages still fill while the output waits.
// Reset clears only the stage valid bits; payload registers are not reset.
module julian_day_to_calendar_date (
	input  logic       clk,
	input  logic       arst_n,
	jdc_req_if.sink    req,
	jdc_rsp_if.source  rsp
);
	import jdc_pkg::*;

	logic [NSTG-1:0] en;
	logic [DN_W-1:0] jd_s3;
	logic [HR_W-1:0] hh_s5, hh_s6, hh_s7, hh_s8, hh_s9;
	logic [MI_W-1:0] mi_s5, mi_s6, mi_s7, mi_s8, mi_s9;
	logic [SE_W-1:0] ss_s5, ss_s6, ss_s7, ss_s8, ss_s9;
	logic [MS_W-1:0] ms_s5, ms_s6, ms_s7, ms_s8, ms_s9;

	jdc_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.en        (en),
		.out_valid (rsp.valid)
	);

	jdc_split u_split (
		.clk          (clk),
		.en           (en),
		.req_type     (req.req_type),
		.day_number   (req.day_number),
		.epoch_millis (req.epoch_millis),
		.jd_s3        (jd_s3),
		.hh_s5        (hh_s5),
		.mi_s5        (mi_s5),
		.ss_s5        (ss_s5),
		.ms_s5        (ms_s5)
	);

	jdc_date u_date (
		.clk      (clk),
		.en       (en),
		.jd_s3    (jd_s3),
		.year_s9  (rsp.year_out),
		.month_s9 (rsp.month_out),
		.day_s9   (rsp.day_out)
	);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			hh_s6 <= hh_s5;
			mi_s6 <= mi_s5;
			ss_s6 <= ss_s5;
			ms_s6 <= ms_s5;
		end
		if (en[6]) begin
			hh_s7 <= hh_s6;
			mi_s7 <= mi_s6;
			ss_s7 <= ss_s6;
			ms_s7 <= ms_s6;
		end
		if (en[7]) begin
			hh_s8 <= hh_s7;
			mi_s8 <= mi_s7;
			ss_s8 <= ss_s7;
			ms_s8 <= ms_s7;
		end
		if (en[8]) begin
			hh_s9 <= hh_s8;
			mi_s9 <= mi_s8;
			ss_s9 <= ss_s8;
			ms_s9 <= ms_s8;
		end
	end

	assign req.ready      = en[0];
	assign rsp.hour_out   = hh_s9;
	assign rsp.minute_out = mi_s9;
	assign rsp.second_out = ss_s9;
	assign rsp.millis_out = ms_s9;

endmodule

/* rtl/jdc_chk.sv */
// Port-level checks for the calendar date converter and their binding.
module jdc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [jdc_pkg::YR_W-1:0]   year_out,
	input logic [jdc_pkg::MO_W-1:0]          month_out,
	input logic [jdc_pkg::DY_W-1:0]          day_out,
	input logic [jdc_pkg::HR_W-1:0]          hour_out,
	input logic [jdc_pkg::MI_W-1:0]          minute_out,
	input logic [jdc_pkg::SE_W-1:0]          second_out,
	input logic [jdc_pkg::MS_W-1:0]          millis_out
);
	import jdc_pkg::*;

	logic [3:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
		end
	end

	// A waiting result holds its date fields and its milliseconds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(year_out) && $stable(month_out)
			&& $stable(day_out) && $stable(millis_out))
		else $error("result changed while stalled");

	// Requests in flight never exceed the pipeline depth, and no result appears unasked.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(NSTG) && (!rsp_valid || cnt_q != 4'd0))
		else $error("request count out of range");

	// A ready output lets the whole pipeline advance.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("input stalled while output is ready");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1)
		else $error("date field out of range");

	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59
			&& millis_out <= 10'd999)
		else $error("time field out of range");

endmodule

bind julian_day_to_calendar_date jdc_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.year_out   (rsp.year_out),
	.month_out  (rsp.month_out),
	.day_out    (rsp.day_out),
	.hour_out   (rsp.hour_out),
	.minute_out (rsp.minute_out),
	.second_out (rsp.second_out),
	.millis_out (rsp.millis_out)
);
